// ----- hw/rtl/biquad_iir_filter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Biquad filter assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define BIQUAD_IIR_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define BQF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("biquad assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BQF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("biquad assertion failed");
`else
`define BQF_ASSERT_IMP(label, ante, cons)
`define BQF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/bqf_pkg.sv -----
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, types, microcode table and saturation helpers.
// ----------------------------------------------------------------------------
package bqf_pkg;

	localparam int SAMPLE_WIDTH  = 24;
	localparam int COEF_WIDTH    = 18;
	localparam int STATE_WIDTH   = 40;
	localparam int GUARD_BITS    = 8;
	localparam int PROD_SHIFT    = COEF_WIDTH - 2 - GUARD_BITS;
	localparam int PROD_WIDTH    = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int SCALED_WIDTH  = PROD_WIDTH - PROD_SHIFT;
	localparam int ACC_WIDTH     = STATE_WIDTH + 2;
	localparam int NUM_COEFS     = 5;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int STEP_WIDTH    = 3;

	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [STATE_WIDTH-1:0]  state_t;
	typedef logic signed [SCALED_WIDTH-1:0] scaled_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic [STEP_WIDTH-1:0]          step_t;

	// 1.0 in Q2.(COEF_WIDTH-2)
	localparam coef_t COEF_ONE = coef_t'(1 << (COEF_WIDTH - 2));

	localparam acc_t STATE_MAX  = acc_t'({1'b0, {(STATE_WIDTH-1){1'b1}}});
	localparam acc_t STATE_MIN  = -STATE_MAX - acc_t'(1);
	localparam acc_t SAMPLE_MAX = acc_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	localparam acc_t SAMPLE_MIN = -SAMPLE_MAX - acc_t'(1);
	localparam acc_t ROUND_HALF = acc_t'(1 << (GUARD_BITS - 1));

	// Coefficient select; also the configuration register index.
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_W0,
		ACC_LOAD_W1,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		W1_HOLD,
		W1_LOAD,
		W1_SUB
	} w1_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_FINISH
	} seq_op_t;

	typedef struct packed {
		seq_op_t   seq;
		coef_sel_t coef;
		logic      mul_y;
		acc_op_t   acc_op;
		logic      y_wr;
		w1_op_t    w1_op;
		logic      w0_wr;
	} ucode_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_MUL_B0 = 3'd1;
	localparam step_t STEP_MUL_B1 = 3'd2;
	localparam step_t STEP_MUL_B2 = 3'd3;
	localparam step_t STEP_MUL_A1 = 3'd4;
	localparam step_t STEP_MUL_A2 = 3'd5;
	localparam step_t STEP_FINISH = 3'd6;

	// Microcode table: product issued this step lands in the product
	// register and is consumed by the next step.
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{seq: SEQ_NEXT, coef: COEF_B0, mul_y: 1'b0, acc_op: ACC_HOLD,
			y_wr: 1'b0, w1_op: W1_HOLD, w0_wr: 1'b0};
		case (step)
			STEP_IDLE: begin
				w.seq = SEQ_WAIT_IN;
			end
			STEP_MUL_B0: begin
				w.coef = COEF_B0;
			end
			STEP_MUL_B1: begin
				w.coef   = COEF_B1;
				w.acc_op = ACC_LOAD_W0;
			end
			STEP_MUL_B2: begin
				w.coef   = COEF_B2;
				w.y_wr   = 1'b1;
				w.acc_op = ACC_LOAD_W1;
			end
			STEP_MUL_A1: begin
				w.coef  = COEF_A1;
				w.mul_y = 1'b1;
				w.w1_op = W1_LOAD;
			end
			STEP_MUL_A2: begin
				w.coef   = COEF_A2;
				w.mul_y  = 1'b1;
				w.acc_op = ACC_SUB;
			end
			STEP_FINISH: begin
				w.seq   = SEQ_FINISH;
				w.w0_wr = 1'b1;
				w.w1_op = W1_SUB;
			end
			default: begin
				w.seq = SEQ_FINISH;
			end
		endcase
		return w;
	endfunction

	function automatic state_t sat_state(input acc_t v);
		if (v > STATE_MAX)
			return STATE_MAX[STATE_WIDTH-1:0];
		if (v < STATE_MIN)
			return STATE_MIN[STATE_WIDTH-1:0];
		return v[STATE_WIDTH-1:0];
	endfunction

	// Round half up off the guard bits, then clamp to the sample range.
	function automatic sample_t round_sat_sample(input acc_t v);
		acc_t r;
		r = (v + ROUND_HALF) >>> GUARD_BITS;
		if (r > SAMPLE_MAX)
			return SAMPLE_MAX[SAMPLE_WIDTH-1:0];
		if (r < SAMPLE_MIN)
			return SAMPLE_MIN[SAMPLE_WIDTH-1:0];
		return r[SAMPLE_WIDTH-1:0];
	endfunction

endpackage

// ----- hw/rtl/biquad_iir_filter_top.sv -----
// ----------------------------------------------------------------------------
// Biquad IIR filter, transposed direct form II
// Microcoded second-order section with one shared coefficient multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/sample_in takes one signed sample per item;
//   output channel out_valid/out_ready/sample_out returns one saturated sample
//   per item. Coefficients b0, b1, b2, a1, a2 (signed Q2.16, normalized by a0)
//   are written through cfg_write/cfg_index/cfg_data while the filter is idle;
//   an index past a2 is ignored.
// Timing:
//   A seven-step microprogram runs per item on one multiplier: five products
//   issued back to back, plus the wait step and a final write-back step.
//   The result is registered when the write-back step completes; only then
//   is a new item taken, in the wait step. The shared multiplier sets this.
//   The output register holds its item while the next sample is processed.
// Reset:
//   Delay words clear to zero and the coefficients reset to b0 = 1.0 with all
//   others zero, so the filter passes samples through unchanged.
// Stall:
//   If the previous item is still waiting at the output, the final step holds
//   (no state update) until the output register is free.
// ----------------------------------------------------------------------------
`include "biquad_iir_filter_top_assert.svh"

module biquad_iir_filter_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [bqf_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
	input  logic signed [bqf_pkg::COEF_WIDTH-1:0]     cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]   sample_in,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]   sample_out
);

	// Sequencer
	bqf_pkg::step_t   step_q;
	bqf_pkg::step_t   step_next;
	bqf_pkg::ucode_t  ucode;
	logic             stall;
	logic             go;
	logic             in_acc;
	logic             finish;

	// Coefficient bank
	bqf_pkg::coef_t   coef_q [bqf_pkg::NUM_COEFS];

	// Datapath
	bqf_pkg::sample_t x_q;
	bqf_pkg::sample_t y_q;
	bqf_pkg::coef_t   mul_coef;
	bqf_pkg::sample_t mul_val;
	logic signed [bqf_pkg::PROD_WIDTH-1:0] prod;
	bqf_pkg::scaled_t prod_q;
	bqf_pkg::acc_t    prod_ext;
	bqf_pkg::acc_t    acc_q;
	bqf_pkg::state_t  w0_q;
	bqf_pkg::state_t  w1_q;

	// Output register
	logic             out_valid_q;
	bqf_pkg::sample_t sample_out_q;

	// Fetch the control word for the current step.
	assign ucode  = bqf_pkg::ucode_rom(step_q);
	assign finish = (ucode.seq == bqf_pkg::SEQ_FINISH);

	// Hold the final step while the previous result still waits downstream.
	assign stall    = finish && out_valid_q && !out_ready;
	assign go       = !stall;
	assign in_ready = (ucode.seq == bqf_pkg::SEQ_WAIT_IN);
	assign in_acc   = in_valid && in_ready;

	// Step counter: wait for an item, advance, jump back after write-back.
	always_comb begin
		step_next = step_q;
		case (ucode.seq)
			bqf_pkg::SEQ_WAIT_IN: begin
				if (in_valid)
					step_next = step_q + bqf_pkg::step_t'(1);
			end
			bqf_pkg::SEQ_NEXT: begin
				step_next = step_q + bqf_pkg::step_t'(1);
			end
			bqf_pkg::SEQ_FINISH: begin
				if (go)
					step_next = bqf_pkg::STEP_IDLE;
			end
			default: begin
				step_next = bqf_pkg::STEP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bqf_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	// Coefficient registers; drop writes beyond the last coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bqf_pkg::NUM_COEFS; i++)
				coef_q[i] <= (i == int'(bqf_pkg::COEF_B0)) ? bqf_pkg::COEF_ONE : '0;
		end else if (cfg_write &&
			cfg_index < bqf_pkg::CFG_IDX_WIDTH'(bqf_pkg::NUM_COEFS)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Shared multiplier: coefficient times x or y, scaled to state units.
	assign mul_coef = coef_q[ucode.coef];
	assign mul_val  = ucode.mul_y ? y_q : x_q;
	assign prod     = mul_coef * mul_val;
	assign prod_ext = bqf_pkg::acc_t'(prod_q);

	always_ff @(posedge clk) begin
		if (in_acc)
			x_q <= sample_in;
		// Hold the last product while write-back stalls; w1 still needs it.
		if (go)
			prod_q <= bqf_pkg::scaled_t'(prod >>> bqf_pkg::PROD_SHIFT);
		if (ucode.y_wr)
			y_q <= bqf_pkg::round_sat_sample(acc_q);
		case (ucode.acc_op)
			bqf_pkg::ACC_LOAD_W0: acc_q <= prod_ext + bqf_pkg::acc_t'(w0_q);
			bqf_pkg::ACC_LOAD_W1: acc_q <= prod_ext + bqf_pkg::acc_t'(w1_q);
			bqf_pkg::ACC_SUB:     acc_q <= acc_q - prod_ext;
			default:              acc_q <= acc_q;
		endcase
	end

	// Delay words: update only once the write-back step really completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
		end else if (go) begin
			if (ucode.w0_wr)
				w0_q <= bqf_pkg::sat_state(acc_q);
			case (ucode.w1_op)
				bqf_pkg::W1_LOAD: w1_q <= bqf_pkg::sat_state(prod_ext);
				bqf_pkg::W1_SUB:  w1_q <= bqf_pkg::sat_state(bqf_pkg::acc_t'(w1_q) - prod_ext);
				default:          w1_q <= w1_q;
			endcase
		end
	end

	// Output register: load on write-back, else release on handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && go)
			sample_out_q <= y_q;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// An accepted item starts the product sequence.
	`BQF_ASSERT_NXT(a_accept_starts, in_valid && in_ready, step_q == bqf_pkg::STEP_MUL_B0)
	// A new result only appears right after a completed write-back step.
	`BQF_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(finish && go))
	// A completed write-back returns to the wait step with the result posted.
	`BQF_ASSERT_NXT(a_finish_returns, finish && go, step_q == bqf_pkg::STEP_IDLE && out_valid_q)

endmodule
